>>> rtl/tgd_pkg.sv
// tgd_pkg: shared types and constants for the tile id decode core.
// Holds beat structs, pipeline control struct, register indexes and codes.
// No dependencies.
`default_nettype none

package tgd_pkg;

  // Field widths
  localparam int RAW_W    = 32;
  localparam int ID_W     = 29;
  localparam int COLS_W   = 12;
  localparam int SIZE_W   = 8;
  localparam int CELL_W   = 8;
  localparam int DEST_W   = 14;
  localparam int SRCX_W   = 20;
  localparam int SRCY_W   = 37;
  localparam int ROT_W    = 2;

  // Flip flag positions in the raw id
  localparam int FLAG_H_BIT = 31;
  localparam int FLAG_V_BIT = 30;
  localparam int FLAG_D_BIT = 29;

  // Render tile size in destination pixels
  localparam int RENDER_TILE_SIZE = 32;

  // Divider: dividend width and quotient bits resolved per stage
  localparam int DIV_W          = 32;
  localparam int DIV_STEP_BITS  = 4;
  localparam int DIV_STAGES     = DIV_W / DIV_STEP_BITS;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 29;

  localparam logic [CFG_IDX_W-1:0] REG_SET0_FIRST_ID    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET0_COLUMNS     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET0_TILE_WIDTH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SET0_TILE_HEIGHT = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SET1_FIRST_ID    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SET1_COLUMNS     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SET1_TILE_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SET1_TILE_HEIGHT = 4'd7;

  // Reset values of the registers
  localparam logic [ID_W-1:0]   SET0_FIRST_ID_RST = 29'd1;
  localparam logic [ID_W-1:0]   SET1_FIRST_ID_RST = 29'h1FFF_FFFF;
  localparam logic [COLS_W-1:0] COLUMNS_RST       = 12'd0;
  localparam logic [SIZE_W-1:0] TILE_SIZE_RST     = 8'd32;

  // Rotation codes
  localparam logic [ROT_W-1:0] ROT_NONE    = 2'd0;
  localparam logic [ROT_W-1:0] ROT_PLUS90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_MINUS90 = 2'd2;

  typedef struct packed {
    logic [RAW_W-1:0]  raw_tile_id;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
  } in_beat_t;

  typedef struct packed {
    logic              drawn;
    logic              set_select;
    logic [SRCX_W-1:0] source_x;
    logic [SRCY_W-1:0] source_y;
    logic [SIZE_W-1:0] source_width;
    logic [SIZE_W-1:0] source_height;
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;
    logic [ROT_W-1:0]  rotation;
    logic              mirror_x;
    logic              mirror_y;
  } out_beat_t;

  // Per-item control that rides down the pipeline next to the divider
  typedef struct packed {
    logic              skip;
    logic              sel;
    logic [COLS_W-1:0] cols;
    logic [SIZE_W-1:0] tw;
    logic [SIZE_W-1:0] th;
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;
    logic [ROT_W-1:0]  rot;
    logic              mx;
    logic              my;
  } pipe_t;

endpackage

`default_nettype wire

>>> rtl/tile_gid_decode_core.sv
// tile_gid_decode_core: decodes one map cell per beat into a tile draw request.
// Depends on tgd_pkg (beat structs, pipeline struct, codes and widths).
`default_nettype none

// Usage
// - Input: drive in_data and raise start; a beat is taken at every edge with
//   start high and busy low. busy is always low, so one beat per cycle.
// - Output: out_valid pulses for one cycle with out_data; results come out
//   in input order and the receiver cannot stall them.
// - Config: cfg_we, cfg_index and cfg_wdata write one register per edge;
//   indexes above 7 are ignored. The user must write only while no beat is
//   in flight; the block itself does not enforce this.
// - Pipeline: one stage for tileset choice and flip decode, one for the
//   local id subtract, eight divider stages (4 quotient bits each, 32 in
//   all) and one stage for the column and row scaling multiplies.
// - Throughput: one beat per cycle, set by the fully pipelined divider.
// - Reset: synchronous rst_n clears all valid bits and loads the register
//   reset values; nothing comes out until new beats are accepted.
module tile_gid_decode_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire tgd_pkg::in_beat_t             in_data,
  output logic                               out_valid,
  output tgd_pkg::out_beat_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [tgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tgd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tgd_pkg::*;

  localparam int PIPE_LAT = DIV_STAGES + 3;

  // Configuration registers
  logic [ID_W-1:0]   set0_first_r, set1_first_r;
  logic [COLS_W-1:0] set0_cols_r, set1_cols_r;
  logic [SIZE_W-1:0] set0_tw_r, set0_th_r, set1_tw_r, set1_th_r;

  logic in_accept;

  // Stage 1: choice and decode
  logic              s1_v_r;
  pipe_t             s1_ctl_r, s1_ctl_nxt;
  logic [ID_W-1:0]   s1_id_r, s1_id_nxt;
  logic [ID_W-1:0]   s1_first_r, s1_first_nxt;

  // Divider pipe: entry 0 holds the subtract result
  logic              dv_r   [0:DIV_STAGES];
  pipe_t             dctl_r [0:DIV_STAGES];
  logic [DIV_W-1:0]  dqn_r  [0:DIV_STAGES];
  logic [COLS_W-1:0] drem_r [0:DIV_STAGES];

  // Output register
  logic      out_valid_r;
  out_beat_t out_data_r, out_data_nxt;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // One restoring division step: shift in the next dividend bit
  function automatic logic [COLS_W+DIV_W-1:0] div_step(
    input logic [COLS_W-1:0] rem,
    input logic [DIV_W-1:0]  qn,
    input logic [COLS_W-1:0] cols
  );
    logic [COLS_W:0]   trial;
    logic              ge;
    logic [COLS_W-1:0] rem_n;
    trial = {rem, qn[DIV_W-1]};
    ge    = trial >= {1'b0, cols};
    rem_n = ge ? COLS_W'(trial - {1'b0, cols}) : trial[COLS_W-1:0];
    return {rem_n, qn[DIV_W-2:0], ge};
  endfunction

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set0_first_r <= SET0_FIRST_ID_RST;
      set0_cols_r  <= COLUMNS_RST;
      set0_tw_r    <= TILE_SIZE_RST;
      set0_th_r    <= TILE_SIZE_RST;
      set1_first_r <= SET1_FIRST_ID_RST;
      set1_cols_r  <= COLUMNS_RST;
      set1_tw_r    <= TILE_SIZE_RST;
      set1_th_r    <= TILE_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET0_FIRST_ID:    set0_first_r <= cfg_wdata[ID_W-1:0];
        REG_SET0_COLUMNS:     set0_cols_r  <= cfg_wdata[COLS_W-1:0];
        REG_SET0_TILE_WIDTH:  set0_tw_r    <= cfg_wdata[SIZE_W-1:0];
        REG_SET0_TILE_HEIGHT: set0_th_r    <= cfg_wdata[SIZE_W-1:0];
        REG_SET1_FIRST_ID:    set1_first_r <= cfg_wdata[ID_W-1:0];
        REG_SET1_COLUMNS:     set1_cols_r  <= cfg_wdata[COLS_W-1:0];
        REG_SET1_TILE_WIDTH:  set1_tw_r    <= cfg_wdata[SIZE_W-1:0];
        REG_SET1_TILE_HEIGHT: set1_th_r    <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: tileset choice, flip decode and anchor
  always_comb begin
    logic [ID_W-1:0]   id;
    logic              fh, fv, fd;
    logic              ge0, ge1;
    logic [ID_W-1:0]   first;
    logic [COLS_W-1:0] cols;
    logic [SIZE_W-1:0] tw, th;
    logic              offx, offy;
    logic [ROT_W-1:0]  rot;
    logic              mx, my;
    logic [16:0]       dx_full, dy_full;

    id  = in_data.raw_tile_id[ID_W-1:0];
    fh  = in_data.raw_tile_id[FLAG_H_BIT];
    fv  = in_data.raw_tile_id[FLAG_V_BIT];
    fd  = in_data.raw_tile_id[FLAG_D_BIT];
    ge0 = id >= set0_first_r;
    ge1 = id >= set1_first_r;

    if (ge1) begin
      first = set1_first_r;
      cols  = set1_cols_r;
      tw    = set1_tw_r;
      th    = set1_th_r;
    end else begin
      first = set0_first_r;
      cols  = set0_cols_r;
      tw    = set0_tw_r;
      th    = set0_th_r;
    end

    // eight flip states
    rot  = ROT_NONE;
    mx   = 1'b0;
    my   = 1'b0;
    offx = 1'b0;
    offy = 1'b0;
    case ({fd, fh, fv})
      3'b000: ;
      3'b001: begin my = 1'b1; offy = 1'b1; end
      3'b010: begin mx = 1'b1; offx = 1'b1; end
      3'b011: begin mx = 1'b1; my = 1'b1; offx = 1'b1; offy = 1'b1; end
      3'b100: begin rot = ROT_PLUS90; offx = 1'b1; end
      3'b110: begin rot = ROT_MINUS90; offy = 1'b1; end
      3'b101: begin rot = ROT_PLUS90; my = 1'b1; offx = 1'b1; offy = 1'b1; end
      default: begin rot = ROT_MINUS90; my = 1'b1; end
    endcase

    dx_full = 17'(in_data.cell_x) * 17'(RENDER_TILE_SIZE)
            + (offx ? 17'(RENDER_TILE_SIZE) : 17'd0);
    dy_full = 17'(in_data.cell_y) * 17'(RENDER_TILE_SIZE)
            + (offy ? 17'(RENDER_TILE_SIZE) : 17'd0);

    s1_ctl_nxt.skip   = (id == '0) || !ge0 || (cols == '0);
    s1_ctl_nxt.sel    = ge1;
    s1_ctl_nxt.cols   = cols;
    s1_ctl_nxt.tw     = tw;
    s1_ctl_nxt.th     = th;
    s1_ctl_nxt.dest_x = dx_full[DEST_W-1:0];
    s1_ctl_nxt.dest_y = dy_full[DEST_W-1:0];
    s1_ctl_nxt.rot    = rot;
    s1_ctl_nxt.mx     = mx;
    s1_ctl_nxt.my     = my;
    s1_id_nxt         = id;
    s1_first_nxt      = first;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r   <= s1_ctl_nxt;
    s1_id_r    <= s1_id_nxt;
    s1_first_r <= s1_first_nxt;
  end

  // Stage 2: local id, divider seed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    dctl_r[0] <= s1_ctl_r;
    dqn_r[0]  <= DIV_W'(s1_id_r - s1_first_r);
    drem_r[0] <= '0;
  end

  // Divider stages: DIV_STEP_BITS quotient bits each
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [DIV_W-1:0]  qn_nxt;
    logic [COLS_W-1:0] rem_nxt;

    always_comb begin
      logic [COLS_W+DIV_W-1:0] st;
      qn_nxt  = dqn_r[k-1];
      rem_nxt = drem_r[k-1];
      for (int b = 0; b < DIV_STEP_BITS; b++) begin
        st      = div_step(rem_nxt, qn_nxt, dctl_r[k-1].cols);
        rem_nxt = st[COLS_W+DIV_W-1:DIV_W];
        qn_nxt  = st[DIV_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else begin
        dv_r[k] <= dv_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      dctl_r[k] <= dctl_r[k-1];
      dqn_r[k]  <= qn_nxt;
      drem_r[k] <= rem_nxt;
    end
  end

  // Final stage: scale column and row by the tile size
  always_comb begin
    pipe_t             c;
    logic [ID_W-1:0]   row;
    logic [COLS_W-1:0] col;
    c   = dctl_r[DIV_STAGES];
    row = dqn_r[DIV_STAGES][ID_W-1:0];
    col = drem_r[DIV_STAGES];
    out_data_nxt = '0;
    if (!c.skip) begin
      out_data_nxt.drawn         = 1'b1;
      out_data_nxt.set_select    = c.sel;
      out_data_nxt.source_x      = SRCX_W'(col) * SRCX_W'(c.tw);
      out_data_nxt.source_y      = SRCY_W'(row) * SRCY_W'(c.th);
      out_data_nxt.source_width  = c.tw;
      out_data_nxt.source_height = c.th;
      out_data_nxt.dest_x        = c.dest_x;
      out_data_nxt.dest_y        = c.dest_y;
      out_data_nxt.rotation      = c.rot;
      out_data_nxt.mirror_x      = c.mx;
      out_data_nxt.mirror_y      = c.my;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // every accepted beat comes out after the fixed latency
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##PIPE_LAT out_valid)
    else $error("accepted beat did not produce a result");

  // no result appears without a matching accepted beat
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, PIPE_LAT))
    else $error("result without accepted beat");

  // a beat that is not drawn carries an all-zero payload
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.drawn |->
      out_data.source_x == '0 && out_data.source_y == '0 &&
      out_data.dest_x == '0 && out_data.dest_y == '0 &&
      out_data.rotation == ROT_NONE && !out_data.mirror_x && !out_data.mirror_y)
    else $error("undrawn result carries data");

  // rotated states never mirror horizontally
  a_rot_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rotation != ROT_NONE |-> !out_data.mirror_x &&
      (out_data.rotation == ROT_PLUS90 || out_data.rotation == ROT_MINUS90))
    else $error("bad rotation or mirror combination");
`endif

endmodule

`default_nettype wire
